[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL; they compile away when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/lscw_pkg.sv]
`default_nettype none
package lscw_pkg;

  localparam logic [1:0] OP_ACK  = 2'd0;
  localparam logic [1:0] OP_ECN  = 2'd1;
  localparam logic [1:0] OP_LOSS = 2'd2;
  localparam logic [1:0] OP_PC   = 2'd3;

  localparam logic [1:0] PH_OPEN     = 2'd0;
  localparam logic [1:0] PH_ECN      = 2'd1;
  localparam logic [1:0] PH_RECOVERY = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_INIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RTT_TARGET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_EN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_BETA    = 3'd4;

  localparam logic [15:0] MSS_DEFAULT       = 16'd1200;
  localparam logic [15:0] SEG_RESET         = 16'd1200;
  localparam logic [10:0] ALPHA_INIT_RESET  = 11'd64;
  localparam logic [23:0] RTT_TARGET_RESET  = 24'd25000;
  localparam logic        SCALE_EN_RESET    = 1'b1;
  localparam logic [9:0]  BETA_RESET        = 10'd717;

  localparam int RESET_WINDOW_SEGMENTS = 10;
  localparam int PC_WINDOW_SEGMENTS    = 2;
  localparam int SRTT_OLD_WEIGHT       = 7;
  localparam int SRTT_SHIFT            = 3;
  localparam int BETA_SHIFT            = 10;
  localparam int ALPHA_OUT_W           = 11;

  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = 72;
  localparam int DIV_W   = 64;

  typedef struct packed {
    logic [15:0] seg;
    logic [10:0] alpha_init;
    logic [23:0] target;
    logic        scale_en;
    logic [9:0]  beta;
  } cfg_t;

  typedef struct packed {
    logic        is_ack;
    logic        is_ecn;
    logic        is_loss;
    logic        is_pc;
    logic [31:0] acked;
    logic [23:0] rtt;
    logic [31:0] ce;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/l4s_scalable_congestion_window.sv]
`default_nettype none
`include "assert_macros.svh"
// Prague-style congestion window engine for one connection. Push one event
// (ack, ECN report, loss, persistent congestion) into the input queue; one
// result, the full state after that event, comes out of the result register
// in request order. The input side holds two requests, so until it is full
// it keeps taking events while the engine works and while a result waits to
// be popped. The engine handles one request at a time: a persistent
// congestion event, an ignored event or a slow start ack needs neither
// arithmetic unit; a loss runs through the shared shift-add multiplier only,
// and every other event runs through it and through the shared restoring
// divider. Those two units set the rate. Configuration writes are always
// taken (cfg_ready is tied high) and must only be issued while the block is
// idle. segment_size 0 stands for a 1200-byte segment.
module l4s_scalable_congestion_window #(
  parameter int ALPHA_SHIFT         = 10,
  parameter int EWMA_SHIFT          = 4,
  parameter int MIN_WINDOW_SEGMENTS = 2,
  parameter int RTT_SCALE_FLOOR_US  = 500,
  parameter int VIRTUAL_RTT_SHIFT   = 3,
  parameter int WINDOW_BITS         = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [1:0]   operation,
  input  wire logic [31:0]  acked_byte_count,
  input  wire logic [23:0]  rtt_sample_us,
  input  wire logic [31:0]  ce_mark_count,
  output logic              empty,
  input  wire logic         pop,
  output logic [31:0]       window_bytes,
  output logic [31:0]       slow_start_threshold,
  output logic [10:0]       marking_fraction,
  output logic [1:0]        phase,
  output logic              slow_start_flag,
  output logic [23:0]       smoothed_rtt_us,
  output logic [23:0]       minimum_rtt_us,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_data
);
  import lscw_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  logic res_valid;

  // configuration registers; writes to unused indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seg <= SEG_RESET;
      cfg.alpha_init <= ALPHA_INIT_RESET;
      cfg.target <= RTT_TARGET_RESET;
      cfg.scale_en <= SCALE_EN_RESET;
      cfg.beta <= BETA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEGMENT_SIZE: cfg.seg <= cfg_data[15:0];
        CFG_ALPHA_INIT:   cfg.alpha_init <= cfg_data[10:0];
        CFG_RTT_TARGET:   cfg.target <= cfg_data;
        CFG_SCALE_EN:     cfg.scale_en <= cfg_data[0];
        CFG_LOSS_BETA:    cfg.beta <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify requests into a short queue
  lscw_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .operation        (operation),
    .acked_byte_count (acked_byte_count),
    .rtt_sample_us    (rtt_sample_us),
    .ce_mark_count    (ce_mark_count),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_ready        (cmd_ready)
  );

  // back: state update engine with its result register
  lscw_back #(
    .ALPHA_SHIFT         (ALPHA_SHIFT),
    .EWMA_SHIFT          (EWMA_SHIFT),
    .MIN_WINDOW_SEGMENTS (MIN_WINDOW_SEGMENTS),
    .RTT_SCALE_FLOOR_US  (RTT_SCALE_FLOOR_US),
    .VIRTUAL_RTT_SHIFT   (VIRTUAL_RTT_SHIFT),
    .WINDOW_BITS         (WINDOW_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_ready     (cmd_ready),
    .res_valid     (res_valid),
    .res_pop       (pop),
    .res_window    (window_bytes),
    .res_threshold (slow_start_threshold),
    .res_alpha     (marking_fraction),
    .res_phase     (phase),
    .res_slow      (slow_start_flag),
    .res_srtt      (smoothed_rtt_us),
    .res_min_rtt   (minimum_rtt_us)
  );

  assign empty = !res_valid;

  // slow start only ever runs in the open phase
  `ASSERT_IMPLIES(a_slow_start_open, clk, rst, !empty && slow_start_flag, phase == PH_OPEN)
  // smoothed RTT stays zero only until the first sample, before any minimum
  `ASSERT_IMPLIES(a_rtt_first_sample, clk, rst, !empty && smoothed_rtt_us == 24'd0, minimum_rtt_us == 24'hFF_FFFF)
  // an accepted request is queued for the engine on the next cycle
  `ASSERT_NEXT(a_push_queued, clk, rst, push && !full, cmd_valid)

endmodule
`default_nettype wire

[rtl/lscw_front.sv]
`default_nettype none
module lscw_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    operation,
  input  wire logic [31:0]   acked_byte_count,
  input  wire logic [23:0]   rtt_sample_us,
  input  wire logic [31:0]   ce_mark_count,
  output logic               cmd_valid,
  output lscw_pkg::cmd_t     cmd,
  input  wire logic          cmd_ready
);
  import lscw_pkg::*;

  localparam int Q_DEPTH = 2;
  localparam int PTR_W = $clog2(Q_DEPTH);

  cmd_t ent [Q_DEPTH];
  cmd_t cmd_in;
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0] count;
  logic [PTR_W:0] count_next;
  logic do_push;
  logic do_pop;

  // classify the event kind on entry
  always_comb begin
    cmd_in = '0;
    cmd_in.acked = acked_byte_count;
    cmd_in.rtt = rtt_sample_us;
    cmd_in.ce = ce_mark_count;
    case (operation)
      OP_ACK:  cmd_in.is_ack = 1'b1;
      OP_ECN:  cmd_in.is_ecn = 1'b1;
      OP_LOSS: cmd_in.is_loss = 1'b1;
      OP_PC:   cmd_in.is_pc = 1'b1;
      default: cmd_in.is_pc = 1'b1;
    endcase
  end

  assign full = (count == (PTR_W + 1)'(Q_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd = ent[rptr];
  assign do_push = push && !full;
  assign do_pop = cmd_valid && cmd_ready;

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wptr] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

[rtl/lscw_mul.sv]
`default_nettype none
module lscw_mul (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [lscw_pkg::MUL_A_W-1:0]    a,
  input  wire logic [lscw_pkg::MUL_B_W-1:0]    b,
  output logic                                 done,
  output logic [lscw_pkg::MUL_P_W-1:0]         product
);
  import lscw_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic busy;
  logic [CNT_W-1:0] cnt;
  logic [MUL_P_W-1:0] mc;
  logic [MUL_B_W-1:0] mp;

  // one multiplier bit per cycle, shift and add
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc <= MUL_P_W'(a);
      mp <= b;
      product <= '0;
    end else if (busy) begin
      if (mp[0]) begin
        product <= product + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
  end

endmodule
`default_nettype wire

[rtl/lscw_div.sv]
`default_nettype none
module lscw_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [lscw_pkg::DIV_W-1:0]    dividend,
  input  wire logic [lscw_pkg::DIV_W-1:0]    divisor,
  output logic                               done,
  output logic [lscw_pkg::DIV_W-1:0]         quotient
);
  import lscw_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] rem_diff;
  logic fits;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem[DIV_W-1:0], quotient[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, dsr};
  assign fits = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem <= fits ? rem_diff : rem_sh;
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

[rtl/lscw_back.sv]
`default_nettype none
module lscw_back #(
  parameter int ALPHA_SHIFT         = 10,
  parameter int EWMA_SHIFT          = 4,
  parameter int MIN_WINDOW_SEGMENTS = 2,
  parameter int RTT_SCALE_FLOOR_US  = 500,
  parameter int VIRTUAL_RTT_SHIFT   = 3,
  parameter int WINDOW_BITS         = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lscw_pkg::cfg_t cfg,
  input  wire logic           cmd_valid,
  input  wire lscw_pkg::cmd_t cmd,
  output logic                cmd_ready,
  output logic                res_valid,
  input  wire logic           res_pop,
  output logic [31:0]         res_window,
  output logic [31:0]         res_threshold,
  output logic [10:0]         res_alpha,
  output logic [1:0]          res_phase,
  output logic                res_slow,
  output logic [23:0]         res_srtt,
  output logic [23:0]         res_min_rtt
);
  import lscw_pkg::*;

  localparam int WB = WINDOW_BITS;
  localparam int AW = (ALPHA_SHIFT + 1 > ALPHA_OUT_W) ? ALPHA_SHIFT + 1 : ALPHA_OUT_W;
  localparam int CUT_SHIFT = ALPHA_SHIFT + 1;
  localparam logic [MUL_P_W-1:0] WIN_MAX = {{(MUL_P_W - WB){1'b0}}, {WB{1'b1}}};
  localparam logic [AW-1:0] ALPHA_TOP = {{(AW - 1){1'b0}}, 1'b1} << ALPHA_SHIFT;
  localparam logic [23:0] RTT_FLOOR = 24'(RTT_SCALE_FLOOR_US);
  localparam logic [WB-1:0] WIN_RESET = WB'(RESET_WINDOW_SEGMENTS * SEG_RESET);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ACK_MUL  = 4'd1;
  localparam logic [3:0] S_ACK_DIV  = 4'd2;
  localparam logic [3:0] S_SC_MUL   = 4'd3;
  localparam logic [3:0] S_SC_DIV   = 4'd4;
  localparam logic [3:0] S_ECN_MUL  = 4'd5;
  localparam logic [3:0] S_ECN_DIV  = 4'd6;
  localparam logic [3:0] S_CUT_MUL  = 4'd7;
  localparam logic [3:0] S_LOSS_MUL = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  function automatic logic [WB-1:0] sat_win(input logic [MUL_P_W-1:0] v);
    sat_win = (v > WIN_MAX) ? {WB{1'b1}} : v[WB-1:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [WB-1:0] w);
    logic [MUL_P_W-1:0] wx;
    wx = MUL_P_W'(w);
    sat32 = (wx > MUL_P_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : wx[31:0];
  endfunction

  logic [3:0] state, state_next;
  logic [WB-1:0] window, window_next;
  logic [31:0] threshold, threshold_next;
  logic [AW-1:0] alpha, alpha_next;
  logic [1:0] phase, phase_next;
  logic slow, slow_next;
  logic [23:0] srtt, srtt_next;
  logic [23:0] min_rtt, min_rtt_next;
  logic [63:0] acc, acc_next;
  logic [63:0] tot, tot_next;
  logic [31:0] sc_val, sc_val_next;
  logic sc_cut, sc_cut_next;

  logic mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic mul_done;
  logic [MUL_P_W-1:0] mul_p;
  logic div_start;
  logic [DIV_W-1:0] div_n;
  logic [DIV_W-1:0] div_d;
  logic div_done;
  logic [DIV_W-1:0] div_q;

  logic [15:0] mss;
  logic [21:0] floor_w;
  logic [17:0] pc_w;
  logic [23:0] r_eff;
  logic sc_skip;
  logic [23:0] srtt_upd;
  logic [MUL_P_W-1:0] win72;
  logic [MUL_P_W-1:0] floor72;
  logic [31:0] inc;
  logic [31:0] v_shr;
  logic [31:0] s_res;
  logic [47:0] mark_bytes;
  logic [64:0] sum65;
  logic [63:0] total;
  logic [AW+1:0] na_raw;
  logic [AW-1:0] na;
  logic [MUL_P_W-1:0] red;
  logic [MUL_P_W-1:0] red1;
  logic [MUL_P_W-1:0] cut_w;
  logic [MUL_P_W-1:0] cut_f;
  logic [WB-1:0] cut_win;
  logic [MUL_P_W-1:0] loss_w;
  logic [MUL_P_W-1:0] loss_f;
  logic [WB-1:0] loss_win;
  logic [WB-1:0] ss_win;
  logic [WB-1:0] ca_win;
  logic [WB-1:0] ca_skip_win;
  logic [WB-1:0] pc_win;
  logic [WB-1:0] win_div;
  logic res_load;

  lscw_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  lscw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  assign mss = (cfg.seg == '0) ? MSS_DEFAULT : cfg.seg;
  assign floor_w = 22'(MIN_WINDOW_SEGMENTS) * {6'b0, mss};
  assign pc_w = 18'(PC_WINDOW_SEGMENTS) * {2'b0, mss};
  assign r_eff = (srtt < RTT_FLOOR) ? RTT_FLOOR : srtt;
  assign sc_skip = !cfg.scale_en || (srtt == '0) || (r_eff >= cfg.target);
  assign srtt_upd = (srtt == '0) ? cmd.rtt :
      24'(({3'b0, srtt} * 27'(SRTT_OLD_WEIGHT) + {3'b0, cmd.rtt}) >> SRTT_SHIFT);

  assign win72 = MUL_P_W'(window);
  assign floor72 = MUL_P_W'(floor_w);
  assign win_div = (window == '0) ? {{(WB - 1){1'b0}}, 1'b1} : window;

  // avoidance increase and virtual RTT scaling
  assign inc = (|div_q[DIV_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
  assign v_shr = sc_val >> VIRTUAL_RTT_SHIFT;
  assign s_res = (div_q[31:0] < v_shr) ? v_shr : div_q[31:0];
  assign ss_win = sat_win(win72 + MUL_P_W'(cmd.acked));
  assign ca_win = sat_win(win72 + MUL_P_W'(s_res));
  assign ca_skip_win = sat_win(win72 + MUL_P_W'(inc));

  // marking fraction EWMA
  assign mark_bytes = mul_p[47:0];
  assign sum65 = {1'b0, acc} + {17'b0, mark_bytes};
  assign total = sum65[64] ? {64{1'b1}} : sum65[63:0];
  assign na_raw = (AW + 2)'(alpha) - (AW + 2)'(alpha >> EWMA_SHIFT)
      + (AW + 2)'(div_q[AW:0] >> EWMA_SHIFT);
  assign na = (na_raw == '0) ? {{(AW - 1){1'b0}}, 1'b1} :
      (na_raw > (AW + 2)'(ALPHA_TOP)) ? ALPHA_TOP : na_raw[AW-1:0];

  // ECN cut and loss decrease
  assign red = mul_p >> CUT_SHIFT;
  assign red1 = (red == '0) ? MUL_P_W'(1) : red;
  assign cut_w = (red1 > win72) ? '0 : win72 - red1;
  assign cut_f = (cut_w < floor72) ? floor72 : cut_w;
  assign cut_win = sat_win(cut_f);
  assign loss_w = mul_p >> BETA_SHIFT;
  assign loss_f = (loss_w < floor72) ? floor72 : loss_w;
  assign loss_win = sat_win(loss_f);
  assign pc_win = sat_win(MUL_P_W'(pc_w));

  assign cmd_ready = (state == S_IDLE);
  assign res_load = (state == S_DONE) && (!res_valid || res_pop);

  always_comb begin
    state_next = state;
    window_next = window;
    threshold_next = threshold;
    alpha_next = alpha;
    phase_next = phase;
    slow_next = slow;
    srtt_next = srtt;
    min_rtt_next = min_rtt;
    acc_next = acc;
    tot_next = tot;
    sc_val_next = sc_val;
    sc_cut_next = sc_cut;
    mul_start = 1'b0;
    mul_a = MUL_A_W'(window);
    mul_b = '0;
    div_start = 1'b0;
    div_n = '0;
    div_d = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_ack) begin
            if (cmd.rtt != '0) begin
              srtt_next = srtt_upd;
              if (cmd.rtt < min_rtt) begin
                min_rtt_next = cmd.rtt;
              end
            end
            if (phase == PH_RECOVERY) begin
              state_next = S_DONE;
            end else if (slow && (MUL_P_W'(window) < MUL_P_W'(threshold))) begin
              window_next = ss_win;
              if (phase == PH_ECN) begin
                phase_next = PH_OPEN;
              end
              state_next = S_DONE;
            end else begin
              slow_next = 1'b0;
              mul_start = 1'b1;
              mul_a = MUL_A_W'(cmd.acked);
              mul_b = MUL_B_W'(mss);
              state_next = S_ACK_MUL;
            end
          end else if (cmd.is_ecn) begin
            if (cmd.ce == '0) begin
              state_next = S_DONE;
            end else begin
              mul_start = 1'b1;
              mul_a = MUL_A_W'(cmd.ce);
              mul_b = MUL_B_W'(mss);
              state_next = S_ECN_MUL;
            end
          end else if (cmd.is_loss) begin
            if (phase == PH_RECOVERY) begin
              state_next = S_DONE;
            end else begin
              mul_start = 1'b1;
              mul_a = MUL_A_W'(window);
              mul_b = MUL_B_W'(cfg.beta);
              state_next = S_LOSS_MUL;
            end
          end else begin
            window_next = pc_win;
            threshold_next = sat32(pc_win);
            phase_next = PH_OPEN;
            slow_next = 1'b1;
            alpha_next = AW'(cfg.alpha_init);
            state_next = S_DONE;
          end
        end
      end
      S_ACK_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n = mul_p[DIV_W-1:0];
          div_d = DIV_W'(win_div);
          state_next = S_ACK_DIV;
        end
      end
      S_ACK_DIV: begin
        if (div_done) begin
          sc_val_next = inc;
          sc_cut_next = 1'b0;
          if (sc_skip) begin
            window_next = ca_skip_win;
            if (phase == PH_ECN) begin
              phase_next = PH_OPEN;
            end
            state_next = S_DONE;
          end else begin
            mul_start = 1'b1;
            mul_a = MUL_A_W'(inc);
            mul_b = r_eff;
            state_next = S_SC_MUL;
          end
        end
      end
      S_SC_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n = mul_p[DIV_W-1:0];
          div_d = DIV_W'(cfg.target);
          state_next = S_SC_DIV;
        end
      end
      S_SC_DIV: begin
        if (div_done) begin
          if (sc_cut) begin
            mul_start = 1'b1;
            mul_a = MUL_A_W'(window);
            mul_b = s_res[MUL_B_W-1:0];
            state_next = S_CUT_MUL;
          end else begin
            window_next = ca_win;
            if (phase == PH_ECN) begin
              phase_next = PH_OPEN;
            end
            state_next = S_DONE;
          end
        end
      end
      S_ECN_MUL: begin
        if (mul_done) begin
          tot_next = total;
          div_start = 1'b1;
          div_n = {16'b0, mark_bytes} << ALPHA_SHIFT;
          div_d = total;
          state_next = S_ECN_DIV;
        end
      end
      S_ECN_DIV: begin
        if (div_done) begin
          alpha_next = na;
          acc_next = tot;
          if (MUL_P_W'(tot) >= win72) begin
            sc_val_next = 32'(na);
            sc_cut_next = 1'b1;
            mul_start = 1'b1;
            if (sc_skip) begin
              mul_a = MUL_A_W'(window);
              mul_b = MUL_B_W'(na);
              state_next = S_CUT_MUL;
            end else begin
              mul_a = MUL_A_W'(na);
              mul_b = r_eff;
              state_next = S_SC_MUL;
            end
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_CUT_MUL: begin
        if (mul_done) begin
          window_next = cut_win;
          phase_next = PH_ECN;
          if (slow) begin
            slow_next = 1'b0;
            threshold_next = sat32(cut_win);
          end
          acc_next = '0;
          state_next = S_DONE;
        end
      end
      S_LOSS_MUL: begin
        if (mul_done) begin
          window_next = loss_win;
          threshold_next = sat32(loss_win);
          phase_next = PH_RECOVERY;
          slow_next = 1'b0;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      window <= WIN_RESET;
      threshold <= 32'hFFFF_FFFF;
      alpha <= AW'(ALPHA_INIT_RESET);
      phase <= PH_OPEN;
      slow <= 1'b1;
      srtt <= '0;
      min_rtt <= 24'hFF_FFFF;
      acc <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      window <= window_next;
      threshold <= threshold_next;
      alpha <= alpha_next;
      phase <= phase_next;
      slow <= slow_next;
      srtt <= srtt_next;
      min_rtt <= min_rtt_next;
      acc <= acc_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tot <= tot_next;
    sc_val <= sc_val_next;
    sc_cut <= sc_cut_next;
    if (res_load) begin
      res_window <= win72[31:0];
      res_threshold <= threshold;
      res_alpha <= alpha[ALPHA_OUT_W-1:0];
      res_phase <= phase;
      res_slow <= slow;
      res_srtt <= srtt;
      res_min_rtt <= min_rtt;
    end
  end

endmodule
`default_nettype wire
